// ----- sv/sled_pkg.sv -----
// Shared types, character codes and decode functions for the escape decoder.
package sled_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int LEN_W = 12;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 12'd255;

	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_X      = 8'd120;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TOO_LONG = 3'd1,
		ST_NO_OPEN  = 3'd2,
		ST_NO_CLOSE = 3'd3,
		ST_BS_END   = 3'd4,
		ST_BAD_ESC  = 3'd5,
		ST_BAD_HEX  = 3'd6,
		ST_INNER_QT = 3'd7
	} status_t;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_BODY = 7'b0000010,
		PH_ESC  = 7'b0000100,
		PH_ZERO = 7'b0001000,
		PH_HEX1 = 7'b0010000,
		PH_HEX2 = 7'b0100000,
		PH_DROP = 7'b1000000
	} phase_t;

	// one queued result: a decoded byte, or a status code in value[2:0]
	typedef struct packed {
		logic       is_status;
		logic [7:0] value;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			r = {1'b1, 4'(c - 8'd48)};
		end else if (c >= 8'd97 && c <= 8'd102) begin
			r = {1'b1, 4'(c - 8'd87)};
		end else if (c >= 8'd65 && c <= 8'd70) begin
			r = {1'b1, 4'(c - 8'd55)};
		end
		return r;
	endfunction

	// {valid, decoded byte}
	function automatic logic [8:0] esc_decode(input logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			8'd97:     r = {1'b1, 8'd7};
			8'd98:     r = {1'b1, 8'd8};
			8'd101:    r = {1'b1, 8'd27};
			8'd102:    r = {1'b1, 8'd12};
			8'd110:    r = {1'b1, 8'd10};
			8'd114:    r = {1'b1, 8'd13};
			8'd116:    r = {1'b1, 8'd9};
			8'd118:    r = {1'b1, 8'd11};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SQUOTE: r = {1'b1, CH_SQUOTE};
			CH_QUOTE:  r = {1'b1, CH_QUOTE};
			default:   r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/string_literal_escape_decoder_unit.sv -----
// String literal escape decoder: one raw byte accepted per cycle unless the result queue is full, results in order.
// Path: a result is pushed into the result queue when its byte is accepted, then moved into the output register.
// Throughput: 1 byte per cycle while the result queue is not full; the queue lets input run while output stalls.
// Reset: arst_n asynchronous active low; phase idle, counts zero, max_length 255.
module string_literal_escape_decoder_unit #(
	parameter int QUEUE_DEPTH = sled_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [sled_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic                        end_of_string,
	output logic [2:0]                  status
);

	logic [sled_pkg::LEN_W-1:0]  max_length_q;
	logic                        push;
	sled_pkg::res_t              push_data;
	logic                        pop;
	logic                        head_valid;
	sled_pkg::res_t              head_data;
	sled_pkg::q_status_t         q_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= sled_pkg::MAX_LENGTH_RESET;
		end else if (cfg_wen) begin
			max_length_q <= cfg_wdata;
		end
	end

	sled_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_length(max_length_q),
		.in_valid  (in_valid),
		.in_byte   (in_byte),
		.last      (last),
		.q_full    (q_st.full),
		.in_stall  (in_stall),
		.push      (push),
		.push_data (push_data)
	);

	sled_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data),
		.q_st      (q_st)
	);

	sled_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_data    (head_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.end_of_string(end_of_string),
		.status       (status)
	);

`ifndef SYNTHESIS
	a_status_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_string |-> out_byte == 8'd0)
		else $error("status item carries a nonzero byte");

	a_byte_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_string |-> status == sled_pkg::ST_OK)
		else $error("decoded byte item carries a status code");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(q_st.full) |-> $past(push) && !$past(pop))
		else $error("queue became full without a push");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.empty |-> !pop)
		else $error("pop from an empty queue");
`endif

endmodule

// ----- sv/sled_front.sv -----
// Front end: accepts raw bytes, tracks literal phase and classifies each byte.
module sled_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sled_pkg::LEN_W-1:0]   max_length,
	input  logic                         in_valid,
	input  logic [7:0]                   in_byte,
	input  logic                         last,
	input  logic                         q_full,
	output logic                         in_stall,
	output logic                         push,
	output sled_pkg::res_t               push_data
);

	sled_pkg::phase_t            phase_q, phase_d;
	logic [sled_pkg::LEN_W-1:0]  count_q, count_d;
	logic [3:0]                  nib_q, nib_d;
	logic [sled_pkg::LEN_W:0]    count_inc;
	logic                        accept;
	logic                        too_long;
	logic                        st_hit;
	sled_pkg::status_t           st_code;
	logic [4:0]                  hex;
	logic [8:0]                  esc;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign count_inc = {1'b0, count_q} + (sled_pkg::LEN_W+1)'(1);
	assign too_long  = count_inc > {1'b0, max_length};
	assign hex       = sled_pkg::hex_decode(in_byte);
	assign esc       = sled_pkg::esc_decode(in_byte);

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		nib_d     = nib_q;
		push      = 1'b0;
		push_data = '0;
		st_hit    = 1'b0;
		st_code   = sled_pkg::ST_OK;
		if (accept) begin
			if (phase_q == sled_pkg::PH_DROP) begin
				if (last) begin
					phase_d = sled_pkg::PH_IDLE;
					count_d = '0;
				end
			end else if (too_long) begin
				st_hit  = 1'b1;
				st_code = sled_pkg::ST_TOO_LONG;
			end else if (phase_q == sled_pkg::PH_IDLE) begin
				count_d = count_inc[sled_pkg::LEN_W-1:0];
				if (in_byte != sled_pkg::CH_QUOTE) begin
					st_hit  = 1'b1;
					st_code = sled_pkg::ST_NO_OPEN;
				end else if (last) begin
					st_hit  = 1'b1;
					st_code = sled_pkg::ST_NO_CLOSE;
				end else begin
					phase_d = sled_pkg::PH_BODY;
				end
			end else if (last) begin
				st_hit = 1'b1;
				if (in_byte != sled_pkg::CH_QUOTE) begin
					st_code = sled_pkg::ST_NO_CLOSE;
				end else if (phase_q == sled_pkg::PH_BODY) begin
					st_code = sled_pkg::ST_OK;
				end else if (phase_q == sled_pkg::PH_ESC) begin
					st_code = sled_pkg::ST_BS_END;
				end else begin
					st_code = sled_pkg::ST_BAD_ESC;
				end
			end else begin
				count_d = count_inc[sled_pkg::LEN_W-1:0];
				unique case (phase_q)
					sled_pkg::PH_BODY: begin
						if (in_byte == sled_pkg::CH_BSLASH) begin
							phase_d = sled_pkg::PH_ESC;
						end else if (in_byte == sled_pkg::CH_QUOTE) begin
							st_hit  = 1'b1;
							st_code = sled_pkg::ST_INNER_QT;
						end else begin
							push            = 1'b1;
							push_data.value = in_byte;
						end
					end
					sled_pkg::PH_ESC: begin
						if (in_byte == sled_pkg::CH_ZERO) begin
							phase_d = sled_pkg::PH_ZERO;
						end else if (esc[8]) begin
							push            = 1'b1;
							push_data.value = esc[7:0];
							phase_d         = sled_pkg::PH_BODY;
						end else begin
							st_hit  = 1'b1;
							st_code = sled_pkg::ST_BAD_ESC;
						end
					end
					sled_pkg::PH_ZERO: begin
						if (in_byte == sled_pkg::CH_X) begin
							phase_d = sled_pkg::PH_HEX1;
						end else begin
							st_hit  = 1'b1;
							st_code = sled_pkg::ST_BAD_ESC;
						end
					end
					sled_pkg::PH_HEX1: begin
						if (hex[4]) begin
							nib_d   = hex[3:0];
							phase_d = sled_pkg::PH_HEX2;
						end else begin
							st_hit  = 1'b1;
							st_code = sled_pkg::ST_BAD_HEX;
						end
					end
					sled_pkg::PH_HEX2: begin
						if (hex[4]) begin
							push            = 1'b1;
							push_data.value = {nib_q, hex[3:0]};
							phase_d         = sled_pkg::PH_BODY;
						end else begin
							st_hit  = 1'b1;
							st_code = sled_pkg::ST_BAD_HEX;
						end
					end
					default: begin
						phase_d = sled_pkg::PH_IDLE;
						count_d = '0;
					end
				endcase
			end
			if (st_hit) begin
				push                = 1'b1;
				push_data.is_status = 1'b1;
				push_data.value     = {5'd0, st_code};
				phase_d             = last ? sled_pkg::PH_IDLE : sled_pkg::PH_DROP;
				count_d             = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sled_pkg::PH_IDLE;
			count_q <= '0;
			nib_q   <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			nib_q   <= nib_d;
		end
	end

endmodule

// ----- sv/sled_queue.sv -----
// Short result queue between front and back.
module sled_queue #(
	parameter int DEPTH = sled_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sled_pkg::res_t       push_data,
	input  logic                 pop,
	output logic                 head_valid,
	output sled_pkg::res_t       head_data,
	output sled_pkg::q_status_t  q_st
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sled_pkg::res_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign q_st.full  = count_q == CW'(DEPTH);
	assign q_st.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

// ----- sv/sled_back.sv -----
// Back end: formats queued results into the output register.
module sled_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sled_pkg::res_t  head_data,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            end_of_string,
	output logic [2:0]      status
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        eos_q;
	logic [2:0]  status_q;

	assign pop           = head_valid && (!out_valid_q || !out_stall);
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_string = eos_q;
	assign status        = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q <= head_data.is_status ? 8'd0 : head_data.value;
			eos_q      <= head_data.is_status;
			status_q   <= head_data.is_status ? head_data.value[2:0] : sled_pkg::ST_OK;
		end
	end

endmodule
